### hw/rtl/dpp_pkg.sv
// Drop particle pool: shared types, register indexes and reset values.
// No dependencies; imported by dpp_euler and drop_particle_pool_step.
package dpp_pkg;

    localparam int CntW       = 7;
    localparam int RateW      = 24;
    localparam int AlphaCfgW  = 17;
    localparam int DtW        = 16;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 24;
    localparam int PoolDepthDef = 64;

    localparam logic [RateW-1:0]     GravityRst    = 24'd1310720;
    localparam logic [RateW-1:0]     FadeRst       = 24'd32768;
    localparam logic [RateW-1:0]     GrowRst       = 24'd2621440;
    localparam logic [RateW-1:0]     TargetRst     = 24'd655360;
    localparam logic [AlphaCfgW-1:0] StartAlphaRst = 17'd49152;
    localparam logic [CntW-1:0]      CapacityRst   = 7'd64;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GRAVITY     = 3'd0,
        CFG_FADE_RATE   = 3'd1,
        CFG_GROW_RATE   = 3'd2,
        CFG_TARGET_SIZE = 3'd3,
        CFG_START_ALPHA = 3'd4,
        CFG_CAPACITY    = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_SPAWN = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAWN_MUL,
        S_SPAWN_WR,
        S_TICK_RATE,
        S_TICK_SCAN,
        S_TICK_EMIT,
        S_TICK_EMPTY
    } t_state;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] size;
        logic [31:0] alpha;
    } t_particle;

endpackage

### hw/rtl/dpp_euler.sv
// One explicit Euler step of a single particle, with the survival test.
// Depends on dpp_pkg for t_particle and field widths.
module dpp_euler (
    input  dpp_pkg::t_particle              i_part,
    input  logic [dpp_pkg::RateW-1:0]       i_gdt,
    input  logic [dpp_pkg::RateW-1:0]       i_fdt,
    input  logic [dpp_pkg::RateW-1:0]       i_sdt,
    input  logic [dpp_pkg::RateW-1:0]       i_target,
    output dpp_pkg::t_particle              o_part,
    output logic                            o_alive
);
    import dpp_pkg::*;

    logic [31:0] w_vel_y;
    logic [31:0] w_alpha;

    assign w_vel_y = i_part.vel_y + {8'd0, i_gdt};
    // fade only while alpha is still positive
    assign w_alpha = ($signed(i_part.alpha) > 32'sd0) ? i_part.alpha - {8'd0, i_fdt}
                                                      : i_part.alpha;

    always_comb begin
        o_part       = i_part;
        o_part.vel_y = w_vel_y;
        o_part.pos_x = i_part.pos_x + i_part.vel_x;
        o_part.pos_y = i_part.pos_y + w_vel_y;
        o_part.pos_z = i_part.pos_z + i_part.vel_z;
        o_part.alpha = w_alpha;
        if ($signed(i_part.size) < $signed({8'd0, i_target})) begin
            o_part.size = i_part.size + {8'd0, i_sdt};
        end
    end

    assign o_alive = $signed(w_alpha) > 32'sd0;

endmodule

### hw/rtl/drop_particle_pool_step.sv
// Drop particle pool, top level: pool memory, sequencer, spawn and tick datapaths.
// Depends on dpp_pkg and dpp_euler.
// Spawn: S_SPAWN_MUL, then S_SPAWN_WR, which issues one registered result beat on the ports.
// Tick over N particles with w survivors: S_TICK_RATE, a compaction pass in S_TICK_SCAN,
// then S_TICK_EMIT with one beat per cycle, w beats. When w is 0 a single beat comes
// from S_TICK_EMPTY instead, also on an empty pool. The single-port-read /
// single-port-write pool memory, one entry per cycle, sets both pass lengths.
// One item at a time; results cannot be stalled. Synchronous active-low reset
// clears the pool count and loads the register defaults; pool contents are kept.
module drop_particle_pool_step #(
    parameter int POOL_DEPTH = dpp_pkg::PoolDepthDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item port
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_opcode,
    input  logic [31:0]                     i_start_x,
    input  logic [31:0]                     i_start_y,
    input  logic [31:0]                     i_start_z,
    input  logic [31:0]                     i_dir_x,
    input  logic [31:0]                     i_dir_y,
    input  logic [31:0]                     i_dir_z,
    input  logic [23:0]                     i_drop_size,
    input  logic [dpp_pkg::DtW-1:0]         i_time_step,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [dpp_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [dpp_pkg::CfgDataW-1:0]    i_cfg_data,
    // result beats
    output logic                            o_result_valid,
    output logic                            o_item_valid,
    output logic                            o_accepted,
    output logic [dpp_pkg::CntW-1:0]        o_live_count,
    output logic [31:0]                     o_out_x,
    output logic [31:0]                     o_out_y,
    output logic [31:0]                     o_out_z,
    output logic [31:0]                     o_out_size,
    output logic [31:0]                     o_out_alpha,
    output logic                            o_last
);
    import dpp_pkg::*;

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [CntW-1:0] DepthC = CntW'(POOL_DEPTH);

    typedef struct packed {
        logic rd_en;       // issue a pool read at r_rd_idx
        logic idx_clr;     // rewind read and write indexes
        logic wr_scan;     // write a survivor back at r_wr_idx
        logic spawn_wr;    // spawn write-back cycle
        logic count_load;  // take survivor count as the new pool count
        logic res_spawn;
        logic res_emit;
        logic res_empty;
    } t_ctrl;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    t_ctrl               c;

    logic [RateW-1:0]     r_gravity, r_fade, r_grow, r_target;
    logic [AlphaCfgW-1:0] r_start_alpha;
    logic [CntW-1:0]      r_capacity;

    logic [CntW-1:0]      r_count;
    logic [CntW-1:0]      r_rd_idx;
    logic [CntW-1:0]      r_wr_idx;
    logic                 r_pend;

    // latched item payload
    logic [31:0]          r_sx, r_sy, r_sz, r_dx, r_dy, r_dz;
    logic [23:0]          r_size;
    logic [DtW-1:0]       r_dt;
    // spawn velocities and per-tick increments
    logic [31:0]          r_vx, r_vy, r_vz;
    logic [RateW-1:0]     r_gdt, r_fdt, r_sdt;

    // result beat
    logic                 r_o_valid, r_o_item, r_o_acc, r_o_last;
    logic [CntW-1:0]      r_o_live;
    logic [31:0]          r_o_x, r_o_y, r_o_z, r_o_size, r_o_alpha;

    // pool memory
    t_particle            mem [POOL_DEPTH];
    t_particle            r_rd_data;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    t_particle            w_wr_data;

    // ---------------------------------------------------------------
    // Combinational datapath
    // ---------------------------------------------------------------
    logic                 w_accept;
    logic                 w_room;
    logic                 w_more;
    logic signed [56:0]   w_px, w_py, w_pz;
    logic [39:0]          w_gp, w_fp, w_sp;
    t_particle            w_upd;
    t_particle            w_spawn;
    logic                 w_alive;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_room   = (r_count < r_capacity) && (r_count < DepthC);
    assign w_more   = r_rd_idx < r_count;

    // spawn velocity: floor(dir * gravity / 4) in Q15.16, i.e. product >>> 18
    assign w_px = $signed(r_dx) * $signed({1'b0, r_gravity});
    assign w_py = $signed(r_dy) * $signed({1'b0, r_gravity});
    assign w_pz = $signed(r_dz) * $signed({1'b0, r_gravity});

    // rate * dt, truncated back to Q.16
    assign w_gp = r_gravity * r_dt;
    assign w_fp = r_fade    * r_dt;
    assign w_sp = r_grow    * r_dt;

    dpp_euler u_euler (
        .i_part   (r_rd_data),
        .i_gdt    (r_gdt),
        .i_fdt    (r_fdt),
        .i_sdt    (r_sdt),
        .i_target (r_target),
        .o_part   (w_upd),
        .o_alive  (w_alive)
    );

    always_comb begin
        w_spawn.pos_x = r_sx;
        w_spawn.pos_y = r_sy;
        w_spawn.pos_z = r_sz;
        w_spawn.vel_x = r_vx;
        w_spawn.vel_y = r_vy;
        w_spawn.vel_z = r_vz;
        w_spawn.size  = {8'd0, r_size};
        w_spawn.alpha = {15'd0, r_start_alpha};
    end

    // Survivors are written back compacted: the write index never passes the
    // read index, so a scan never reads an entry it has already rewritten.
    assign w_wr_en   = c.wr_scan || (c.spawn_wr && w_room);
    assign w_wr_addr = c.spawn_wr ? r_count[AW-1:0] : r_wr_idx[AW-1:0];
    assign w_wr_data = c.spawn_wr ? w_spawn : w_upd;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_opcode == OP_TICK) ? S_TICK_RATE : S_SPAWN_MUL;
                end
            end
            S_SPAWN_MUL:  n_state = S_SPAWN_WR;
            S_SPAWN_WR:   n_state = S_IDLE;
            S_TICK_RATE:  n_state = S_TICK_SCAN;
            S_TICK_SCAN: begin
                if (!w_more && !r_pend) begin
                    n_state = (r_wr_idx == '0) ? S_TICK_EMPTY : S_TICK_EMIT;
                end
            end
            S_TICK_EMIT: begin
                if (!w_more && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_EMPTY: n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: control outputs
    // ---------------------------------------------------------------
    always_comb begin
        c = '0;
        unique case (r_state)
            S_IDLE:      ;
            S_SPAWN_MUL: ;
            S_SPAWN_WR: begin
                c.spawn_wr  = 1'b1;
                c.res_spawn = 1'b1;
            end
            S_TICK_RATE: c.idx_clr = 1'b1;
            S_TICK_SCAN: begin
                c.rd_en   = w_more;
                c.wr_scan = r_pend && w_alive;
                if (!w_more && !r_pend) begin
                    c.count_load = 1'b1;
                    c.idx_clr    = 1'b1;
                end
            end
            S_TICK_EMIT: begin
                c.rd_en    = w_more;
                c.res_emit = r_pend;
            end
            S_TICK_EMPTY: c.res_empty = 1'b1;
            default:      ;
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_rd_idx      <= '0;
            r_wr_idx      <= '0;
            r_pend        <= 1'b0;
            r_o_valid     <= 1'b0;
            r_gravity     <= GravityRst;
            r_fade        <= FadeRst;
            r_grow        <= GrowRst;
            r_target      <= TargetRst;
            r_start_alpha <= StartAlphaRst;
            r_capacity    <= CapacityRst;
        end else begin
            r_state   <= n_state;
            r_pend    <= c.rd_en;
            r_o_valid <= c.res_spawn || c.res_emit || c.res_empty;

            if (c.idx_clr) begin
                r_rd_idx <= '0;
                r_wr_idx <= '0;
            end else begin
                if (c.rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (c.wr_scan) begin
                    r_wr_idx <= r_wr_idx + 1'b1;
                end
            end

            if (c.count_load) begin
                r_count <= r_wr_idx;
            end else if (c.spawn_wr && w_room) begin
                r_count <= r_count + 1'b1;
            end

            // unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRAVITY:     r_gravity     <= i_cfg_data;
                    CFG_FADE_RATE:   r_fade        <= i_cfg_data;
                    CFG_GROW_RATE:   r_grow        <= i_cfg_data;
                    CFG_TARGET_SIZE: r_target      <= i_cfg_data;
                    CFG_START_ALPHA: r_start_alpha <= i_cfg_data[AlphaCfgW-1:0];
                    CFG_CAPACITY:    r_capacity    <= i_cfg_data[CntW-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_sz   <= i_start_z;
            r_dx   <= i_dir_x;
            r_dy   <= i_dir_y;
            r_dz   <= i_dir_z;
            r_size <= i_drop_size;
            r_dt   <= i_time_step;
        end
        if (r_state == S_SPAWN_MUL) begin
            r_vx <= w_px[49:18];
            r_vy <= w_py[49:18];
            r_vz <= w_pz[49:18];
        end
        if (r_state == S_TICK_RATE) begin
            r_gdt <= w_gp[39:16];
            r_fdt <= w_fp[39:16];
            r_sdt <= w_sp[39:16];
        end

        // result beat: spawn and empty tick carry zero particle fields
        r_o_item  <= c.res_emit;
        r_o_acc   <= c.res_spawn && w_room;
        r_o_last  <= c.res_spawn || c.res_empty || (c.res_emit && !w_more);
        r_o_x     <= c.res_emit ? r_rd_data.pos_x : '0;
        r_o_y     <= c.res_emit ? r_rd_data.pos_y : '0;
        r_o_z     <= c.res_emit ? r_rd_data.pos_z : '0;
        r_o_size  <= c.res_emit ? r_rd_data.size  : '0;
        r_o_alpha <= c.res_emit ? r_rd_data.alpha : '0;
        if (c.res_spawn) begin
            r_o_live <= w_room ? r_count + 1'b1 : r_count;
        end else begin
            r_o_live <= r_count;
        end
    end

    // ---------------------------------------------------------------
    // Pool memory: one read, one write per cycle, registered read data
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (c.rd_en) begin
            r_rd_data <= mem[r_rd_idx[AW-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_o_valid;
    assign o_item_valid   = r_o_item;
    assign o_accepted     = r_o_acc;
    assign o_live_count   = r_o_live;
    assign o_out_x        = r_o_x;
    assign o_out_y        = r_o_y;
    assign o_out_z        = r_o_z;
    assign o_out_size     = r_o_size;
    assign o_out_alpha    = r_o_alpha;
    assign o_last         = r_o_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DepthC)
        else $error("pool count beyond pool depth");

    a_compact_lag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.wr_scan |-> (r_wr_idx < r_rd_idx))
        else $error("compaction write overtook the read index");

    a_last_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last) |=> !o_result_valid)
        else $error("result beat straight after a final beat");

    a_mid_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> (o_item_valid && !o_accepted))
        else $error("non-final beat without a survivor");

endmodule
